### src/integer_to_ascii_text_unit_assert.svh
// Assertion macros used by the top-level file of this block.
`ifndef INTEGER_TO_ASCII_TEXT_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_TEXT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITOA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("integer_to_ascii_text_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("integer_to_ascii_text_unit: next-cycle check failed");

`endif

### src/itoa_pkg.sv
package itoa_pkg;

    localparam int WORD_BITS  = 32;
    localparam int VALUE_BITS = 32;
    localparam int DEC_DIGITS = (WORD_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
    localparam int DIG_COUNT  = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int BCD_BITS   = 4 * DIG_COUNT;
    localparam int IDX_W      = $clog2(DIG_COUNT);
    localparam int CNT_W      = $clog2(WORD_BITS);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef enum logic [1:0] {
        ACT_HEX  = 2'd0,
        ACT_UDEC = 2'd1,
        ACT_SDEC = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_PRE0,
        ST_PRE1,
        ST_DIG
    } state_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic                 hex;
        logic                 neg;
        logic [WORD_BITS-1:0] mag;
    } item_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        case (nib)
            4'ha:    c = CH_LOW_A;
            4'hb:    c = CH_LOW_A + 8'd1;
            4'hc:    c = CH_LOW_A + 8'd2;
            4'hd:    c = CH_LOW_A + 8'd3;
            4'he:    c = CH_LOW_A + 8'd4;
            4'hf:    c = CH_LOW_F;
            default: c = CH_ZERO + {4'd0, nib};
        endcase
        return c;
    endfunction

endpackage

### src/itoa_front.sv
module itoa_front (
    input  logic                             s_tvalid,
    input  logic [1:0]                       action,
    input  logic [itoa_pkg::VALUE_BITS-1:0] value,
    input  logic                             q_full,
    output logic                             s_tready,
    output logic                             push,
    output itoa_pkg::item_t                  push_item
);

    logic [itoa_pkg::WORD_BITS-1:0] v;
    logic                           neg;
    logic                           known;

    assign v     = value[itoa_pkg::WORD_BITS-1:0];
    assign known = (action == itoa_pkg::ACT_HEX) || (action == itoa_pkg::ACT_UDEC) ||
                   (action == itoa_pkg::ACT_SDEC);
    assign neg   = (action == itoa_pkg::ACT_SDEC) && v[itoa_pkg::WORD_BITS-1];

    // An unused action code is taken and dropped without a result.
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready && known;

    always_comb
    begin
        push_item.hex = (action == itoa_pkg::ACT_HEX);
        push_item.neg = neg;
        // The magnitude is formed unsigned, so the most negative value stays exact.
        push_item.mag = neg ? (~v + itoa_pkg::WORD_BITS'(1)) : v;
    end

endmodule

### src/itoa_queue.sv
module itoa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  itoa_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            valid,
    output itoa_pkg::item_t pop_item
);

    itoa_pkg::item_t               mem_reg [itoa_pkg::QDEPTH];
    logic [itoa_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [itoa_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [itoa_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_push, do_pop;

    assign full     = (count_reg == itoa_pkg::QCNT_W'(itoa_pkg::QDEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == itoa_pkg::QPTR_W'(itoa_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + itoa_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == itoa_pkg::QPTR_W'(itoa_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + itoa_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + itoa_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - itoa_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/itoa_back.sv
module itoa_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  itoa_pkg::item_t q_item,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    itoa_pkg::state_t                state_reg, state_next;
    logic [itoa_pkg::WORD_BITS-1:0]  bin_reg, bin_next;
    logic [itoa_pkg::BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [itoa_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [itoa_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                            hex_reg, hex_next;
    logic                            neg_reg, neg_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [7:0]                      m_tdata_reg, m_tdata_next;
    logic                            m_tlast_reg, m_tlast_next;

    logic                            out_free;
    logic                            emit;
    logic [7:0]                      emit_char;
    logic                            emit_last;
    logic [3:0]                      digs [itoa_pkg::DIG_COUNT];
    logic [itoa_pkg::BCD_BITS-1:0]   bcd_adj;
    logic [itoa_pkg::IDX_W-1:0]      msd;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Digit view of the conversion register, the add-3 correction, and the
    // position of the leading nonzero digit (digit zero when all are zero).
    always_comb
    begin
        msd = '0;
        for (int i = 0; i < itoa_pkg::DIG_COUNT; i++)
        begin
            digs[i] = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (digs[i] >= 4'd5) ? digs[i] + 4'd3 : digs[i];
            if (digs[i] != 4'd0)
            begin
                msd = itoa_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.hex ? itoa_pkg::ST_SCAN : itoa_pkg::ST_CONV;
                end
            end
            itoa_pkg::ST_CONV:
            begin
                if (cnt_reg == itoa_pkg::CNT_W'(itoa_pkg::WORD_BITS - 1))
                begin
                    state_next = itoa_pkg::ST_SCAN;
                end
            end
            itoa_pkg::ST_SCAN:
            begin
                state_next = (hex_reg || neg_reg) ? itoa_pkg::ST_PRE0 : itoa_pkg::ST_DIG;
            end
            itoa_pkg::ST_PRE0:
            begin
                if (out_free)
                begin
                    state_next = hex_reg ? itoa_pkg::ST_PRE1 : itoa_pkg::ST_DIG;
                end
            end
            itoa_pkg::ST_PRE1:
            begin
                if (out_free)
                begin
                    state_next = itoa_pkg::ST_DIG;
                end
            end
            itoa_pkg::ST_DIG:
            begin
                if (out_free && (idx_reg == '0))
                begin
                    state_next = itoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = itoa_pkg::CH_ZERO;
        emit_last = 1'b0;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        hex_next  = hex_reg;
        neg_next  = neg_reg;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    hex_next = q_item.hex;
                    neg_next = q_item.neg;
                    bin_next = q_item.mag;
                    cnt_next = '0;
                    // Hex digits are the nibbles themselves.
                    bcd_next = q_item.hex ? itoa_pkg::BCD_BITS'(q_item.mag) : '0;
                end
            end
            itoa_pkg::ST_CONV:
            begin
                bcd_next = {bcd_adj[itoa_pkg::BCD_BITS-2:0], bin_reg[itoa_pkg::WORD_BITS-1]};
                bin_next = {bin_reg[itoa_pkg::WORD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + itoa_pkg::CNT_W'(1);
            end
            itoa_pkg::ST_SCAN:
            begin
                idx_next = msd;
            end
            itoa_pkg::ST_PRE0:
            begin
                emit      = out_free;
                emit_char = hex_reg ? itoa_pkg::CH_ZERO : itoa_pkg::CH_MINUS;
            end
            itoa_pkg::ST_PRE1:
            begin
                emit      = out_free;
                emit_char = itoa_pkg::CH_X;
            end
            itoa_pkg::ST_DIG:
            begin
                emit      = out_free;
                emit_char = itoa_pkg::hex_char(digs[idx_reg]);
                emit_last = (idx_reg == '0);
                if (out_free && (idx_reg != '0))
                begin
                    idx_next = idx_reg - itoa_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_free)
        begin
            m_tvalid_next = emit;
            m_tdata_next  = emit_char;
            m_tlast_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= itoa_pkg::ST_IDLE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        hex_reg     <= hex_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

### src/integer_to_ascii_text_unit.sv
// Channel  | Direction | tdata            | tuser          | tlast
// s_       | in        | [31:0] value     | [1:0] action   | -
// m_       | out       | [7:0] text_char  | -              | last
//
// In the back part a hex item prints 1 to 8 digits after its prefix.
// A decimal item first goes through the bit-serial binary to BCD conversion, then
// prints a minus sign if it is negative and 1 to 10 digits.
// The two-entry queue lets the front take up to two items while the back is busy.
// Reset clears the control state; no results are pending after it.
// A stall on the result side holds the back part; the front keeps filling the queue until it is full.
module integer_to_ascii_text_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [itoa_pkg::VALUE_BITS-1:0] s_tdata,  // value
    input  logic [1:0]                       s_tuser,  // action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,  // text_char
    output logic                             m_tlast
);

`include "integer_to_ascii_text_unit_assert.svh"

    logic            q_full;
    logic            q_valid;
    logic            q_push;
    logic            q_pop;
    itoa_pkg::item_t push_item;
    itoa_pkg::item_t pop_item;
    logic            last_is_digit;

    itoa_front u_front (
        .s_tvalid  (s_tvalid),
        .action    (s_tuser),
        .value     (s_tdata),
        .q_full    (q_full),
        .s_tready  (s_tready),
        .push      (q_push),
        .push_item (push_item)
    );

    itoa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    itoa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign last_is_digit = ((m_tdata >= itoa_pkg::CH_ZERO) && (m_tdata <= itoa_pkg::CH_NINE)) ||
                           ((m_tdata >= itoa_pkg::CH_LOW_A) && (m_tdata <= itoa_pkg::CH_LOW_F));

    // A pushed item is waiting in the queue on the next cycle.
    `ITOA_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push, q_valid)
    // Back-pressure on the input only comes from a queue that holds items.
    `ITOA_ASSERT_IMP(a_stall_full, clk, rst_n, !s_tready, q_valid)
    // The final character of every text is a digit.
    `ITOA_ASSERT_IMP(a_last_digit, clk, rst_n, m_tvalid && m_tlast, last_is_digit)

endmodule

### tb/tb_integer_to_ascii_text_unit.sv
`timescale 1ns / 100ps

module tb_integer_to_ascii_text_unit;

    // Action code that the block ignores.
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef enum int {
        PACE_FULL,
        PACE_MIXED,
        PACE_SLOW
    } pace_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    text_char_t  pending_text[$];
    text_char_t  want_char;
    int          text_mismatches = 0;
    pace_t       tx_pace = PACE_MIXED;
    pace_t       rx_pace = PACE_MIXED;
    int          rx_hold = 0;
    int          rx_len;

    integer_to_ascii_text_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("FAIL integer_to_ascii_text_unit");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none at full pace.
    function automatic int idle_len(input pace_t pace);
        int r;
        r = $urandom_range(0, 99);
        if (pace == PACE_FULL)
            return 0;
        if (pace == PACE_MIXED)
        begin
            if (r < 55)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(6, 30);
        end
        if (r < 25)
            return 0;
        if (r < 82)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_char(input logic [7:0] ch);
        text_char_t t;
        t.ch   = ch;
        t.last = 1'b0;
        pending_text.push_back(t);
    endfunction

    // Builds the text the block should print for one accepted item.
    function automatic void predict_text(input logic [1:0] act, input logic [31:0] val);
        logic [31:0] mag;
        logic [3:0]  nib;
        logic [7:0]  digits[$];
        bit          started;
        text_char_t  tail;
        if (act == ACT_NONE)
            return;
        if (act == itoa_pkg::ACT_HEX)
        begin
            push_char(itoa_pkg::CH_ZERO);
            push_char(itoa_pkg::CH_X);
            started = 1'b0;
            for (int k = 7; k >= 0; k--)
            begin
                nib = val[4*k +: 4];
                if (nib != 4'd0 || started || k == 0)
                begin
                    started = 1'b1;
                    if (nib < 4'd10)
                        push_char(itoa_pkg::CH_ZERO + 8'(nib));
                    else
                        push_char(itoa_pkg::CH_LOW_A + 8'(nib - 4'd10));
                end
            end
        end
        else
        begin
            mag = val;
            if (act == itoa_pkg::ACT_SDEC && val[31])
            begin
                push_char(itoa_pkg::CH_MINUS);
                mag = ~val + 32'd1;
            end
            do
            begin
                digits.push_front(itoa_pkg::CH_ZERO + 8'(mag % 32'd10));
                mag = mag / 32'd10;
            end
            while (mag != 32'd0);
            foreach (digits[i])
                push_char(digits[i]);
        end
        tail = pending_text.pop_back();
        tail.last = 1'b1;
        pending_text.push_back(tail);
    endfunction

    // Presents one item and returns at the edge where it is accepted.
    task automatic send_word(input logic [1:0] act, input logic [31:0] val);
        int gap;
        gap = idle_len(tx_pace);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_text(act, val);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] pow;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom_range(0, 20);
        if (sel == 1)
        begin
            pow = 32'd1;
            repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
            return pow + $urandom_range(0, 2) - 32'd1;
        end
        if (sel == 2)
            return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'hffff_ffff;
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // Sends n printable items in random modes; ignored items come in between.
    task automatic send_random(input int n);
        logic [1:0]  act;
        logic [31:0] val;
        int          sent;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 19) == 0)
                act = ACT_NONE;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       act = itoa_pkg::ACT_HEX;
                    1:       act = itoa_pkg::ACT_UDEC;
                    default: act = itoa_pkg::ACT_SDEC;
                endcase
            end
            val = pick_value();
            if (act == itoa_pkg::ACT_SDEC && $urandom_range(0, 1) != 0)
                val = ~val + 32'd1;
            send_word(act, val);
            if (act != ACT_NONE)
                sent++;
        end
    endtask

    task automatic test_edge_values();
        tx_pace = PACE_MIXED;
        rx_pace = PACE_MIXED;
        send_word(itoa_pkg::ACT_HEX, 32'h0000_0000);
        send_word(itoa_pkg::ACT_HEX, 32'hffff_ffff);
        send_word(itoa_pkg::ACT_HEX, 32'h8000_0000);
        send_word(itoa_pkg::ACT_HEX, 32'h0000_0001);
        send_word(itoa_pkg::ACT_HEX, 32'h0000_0010);
        send_word(itoa_pkg::ACT_HEX, 32'h0abc_def0);
        send_word(itoa_pkg::ACT_HEX, 32'hdead_beef);
        send_word(itoa_pkg::ACT_UDEC, 32'd0);
        send_word(itoa_pkg::ACT_UDEC, 32'hffff_ffff);
        send_word(itoa_pkg::ACT_UDEC, 32'd9);
        send_word(itoa_pkg::ACT_UDEC, 32'd10);
        send_word(itoa_pkg::ACT_UDEC, 32'd999_999_999);
        send_word(itoa_pkg::ACT_UDEC, 32'd1_000_000_000);
        send_word(ACT_NONE, 32'h0000_0000);
        send_word(itoa_pkg::ACT_SDEC, 32'd0);
        send_word(itoa_pkg::ACT_SDEC, 32'h8000_0000);
        send_word(itoa_pkg::ACT_SDEC, 32'hffff_ffff);
        send_word(itoa_pkg::ACT_SDEC, 32'h7fff_ffff);
        send_word(itoa_pkg::ACT_SDEC, 32'd1);
        send_word(itoa_pkg::ACT_SDEC, 32'hffff_fff6);
        send_word(ACT_NONE, 32'hffff_ffff);
        send_word(itoa_pkg::ACT_UDEC, 32'h8000_0000);
    endtask

    task automatic test_random_words();
        tx_pace = PACE_MIXED;
        rx_pace = PACE_MIXED;
        send_random(150);
    endtask

    // Short bursts, each followed by a pause until all text is out.
    task automatic test_drain_pauses();
        tx_pace = PACE_FULL;
        rx_pace = PACE_MIXED;
        repeat (4)
        begin
            send_random(5);
            wait_drained();
        end
    endtask

    task automatic test_full_rate();
        tx_pace = PACE_FULL;
        rx_pace = PACE_FULL;
        send_random(60);
    endtask

    task automatic test_slow_receiver();
        tx_pace = PACE_SLOW;
        rx_pace = PACE_SLOW;
        send_random(60);
    endtask

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end
        else
        begin
            rx_len = idle_len(rx_pace);
            m_tready <= (rx_len == 0);
            rx_hold  <= (rx_len > 0) ? rx_len - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_text.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual char %h last %b",
                         $time, m_tdata, m_tlast);
                text_mismatches++;
            end
            else
            begin
                want_char = pending_text.pop_front();
                if (m_tdata !== want_char.ch)
                begin
                    $display("%0t: char mismatch, expected %h, actual %h",
                             $time, want_char.ch, m_tdata);
                    text_mismatches++;
                end
                if (m_tlast !== want_char.last)
                begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, want_char.last, m_tlast);
                    text_mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_values();
        test_random_words();
        test_drain_pauses();
        test_full_rate();
        test_slow_receiver();
        wait_drained();
        // Keep checking after the drain so that any unexpected extra character is seen.
        repeat (150) @(posedge clk);
        if (text_mismatches == 0)
            $display("PASS integer_to_ascii_text_unit");
        else
            $display("FAIL integer_to_ascii_text_unit");
        $finish;
    end

endmodule
